// ===== src/tafs_pkg.sv =====
// ----------------------------------------------------------------------------
// tafs_pkg: shared types and constants for the triangle angle pipeline
// Widths of the normalised radicand, root, CORDIC datapath and the arctangent
// table used by every stage of the block.
// ----------------------------------------------------------------------------
package tafs_pkg;

  // default field formats
  localparam int SIDE_WIDTH_DEF = 16;
  localparam int ANGLE_FRAC_DEF = 8;

  // square root datapath: radicand normalised to 120 bits, 60-bit root
  localparam int NORM_BITS = 120;
  localparam int ROOT_BITS = 60;
  localparam int REM_BITS  = 62;

  // CORDIC datapath, angles in radians with 30 fraction bits
  localparam int CORDIC_STEPS = 31;
  localparam int XY_BITS      = 64;
  localparam int Z_BITS       = 34;
  localparam int DEG_BITS     = 64;

  // twice 180/pi with 24 fraction bits (half angle doubled on the way out)
  localparam logic [30:0] DEG_PER_RAD_X2 = 31'd1922527338;

  // stage counts of the sub-blocks
  localparam int NORM_LAT   = 5;
  localparam int CORDIC_LAT = CORDIC_STEPS + 2;

  // control word that travels alongside each request
  typedef struct packed {
    logic vld;
    logic ok;
  } tafs_ctl_t;

  // atan(2^-i), radians, 30 fraction bits, rounded to nearest
  function automatic logic [Z_BITS-1:0] atan_q30(input logic [4:0] idx);
    logic [Z_BITS-1:0] val;
    case (idx)
      5'd0:  val = 34'd843314857;
      5'd1:  val = 34'd497837829;
      5'd2:  val = 34'd263043837;
      5'd3:  val = 34'd133525159;
      5'd4:  val = 34'd67021687;
      5'd5:  val = 34'd33543516;
      5'd6:  val = 34'd16775851;
      5'd7:  val = 34'd8388437;
      5'd8:  val = 34'd4194283;
      5'd9:  val = 34'd2097149;
      5'd10: val = 34'd1048576;
      5'd11: val = 34'd524288;
      5'd12: val = 34'd262144;
      5'd13: val = 34'd131072;
      5'd14: val = 34'd65536;
      5'd15: val = 34'd32768;
      5'd16: val = 34'd16384;
      5'd17: val = 34'd8192;
      5'd18: val = 34'd4096;
      5'd19: val = 34'd2048;
      5'd20: val = 34'd1024;
      5'd21: val = 34'd512;
      5'd22: val = 34'd256;
      5'd23: val = 34'd128;
      5'd24: val = 34'd64;
      5'd25: val = 34'd32;
      5'd26: val = 34'd16;
      5'd27: val = 34'd8;
      5'd28: val = 34'd4;
      5'd29: val = 34'd2;
      5'd30: val = 34'd1;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

// ===== src/triangle_angles_from_sides.sv =====
// ----------------------------------------------------------------------------
// triangle_angles_from_sides: interior angles of a triangle from its sides
// Checks three Q8.8 side lengths and returns the three interior angles in
// degrees through the half-angle form of the law of cosines.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with in_side_a/b/c for one cycle per request. busy stays low,
//   so a new request may be issued on every clock.
//   Each request yields exactly one result: out_strobe is high for one cycle
//   with out_valid_res and out_angle_a/b/c. A zero side or a set that fails
//   the strict triangle inequality gives out_valid_res low and zero angles.
//   Throughput: one request per cycle.
//   The pipeline depth is set by the 60-stage square root pipeline (one root bit per
//   stage) and the 31-stage CORDIC, plus eight stages of products,
//   normalisation, input checks and output scaling.
//   Results leave in request order. The receiver cannot stall, so no request
//   is ever held back.
//   Reset (rst_n low at a clock edge) empties the pipeline; requests in flight
//   are dropped and no strobe follows until new requests arrive.
// ----------------------------------------------------------------------------
module triangle_angles_from_sides #(
  parameter int SIDE_WIDTH      = tafs_pkg::SIDE_WIDTH_DEF,
  parameter int ANGLE_FRAC_BITS = tafs_pkg::ANGLE_FRAC_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [SIDE_WIDTH-1:0]         in_side_a,
  input  logic [SIDE_WIDTH-1:0]         in_side_b,
  input  logic [SIDE_WIDTH-1:0]         in_side_c,
  output logic                          out_strobe,
  output logic                          out_valid_res,
  output logic [8+ANGLE_FRAC_BITS-1:0]  out_angle_a,
  output logic [8+ANGLE_FRAC_BITS-1:0]  out_angle_b,
  output logic [8+ANGLE_FRAC_BITS-1:0]  out_angle_c
);
  import tafs_pkg::*;

  localparam int AW  = 8 + ANGLE_FRAC_BITS;
  localparam int SW  = SIDE_WIDTH;
  localparam int TGT = 180 * (2 ** ANGLE_FRAC_BITS);

  logic [SW:0]   ab, bc, ac;
  logic          ok_nxt;
  tafs_ctl_t     ctl0_r;
  logic [SW+1:0] sum0_r;
  logic [SW:0]   qa0_r, qb0_r, qc0_r;
  logic [SW:0]   q_opp [0:2];
  logic [SW:0]   q_u0  [0:2];
  logic [SW:0]   q_u1  [0:2];
  tafs_ctl_t     norm_ctl [0:2];
  tafs_ctl_t     squ_ctl  [0:2];
  tafs_ctl_t     sqv_ctl  [0:2];
  tafs_ctl_t     cor_ctl  [0:2];
  logic [NORM_BITS-1:0] rad_u [0:2];
  logic [NORM_BITS-1:0] rad_v [0:2];
  logic [ROOT_BITS-1:0] root_u [0:2];
  logic [ROOT_BITS-1:0] root_v [0:2];
  logic [AW-1:0]        ang [0:2];
  logic [AW+1:0]        ang_sum;

  // every request is taken at once
  assign busy = 1'b0;

  // strict triangle inequality on exact sums, no zero side
  assign ab = {1'b0, in_side_a} + {1'b0, in_side_b};
  assign bc = {1'b0, in_side_b} + {1'b0, in_side_c};
  assign ac = {1'b0, in_side_a} + {1'b0, in_side_c};
  assign ok_nxt = (in_side_a != '0) && (in_side_b != '0) && (in_side_c != '0) &&
                  (ab > (SW+1)'(in_side_c)) && (bc > (SW+1)'(in_side_a)) &&
                  (ac > (SW+1)'(in_side_b));

  // capture the request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl0_r <= '0;
    end else begin
      ctl0_r.vld <= start;
      ctl0_r.ok  <= ok_nxt;
    end
  end

  // perimeter and the three excess sums
  always_ff @(posedge clk) begin
    sum0_r <= (SW+2)'(ab) + (SW+2)'(in_side_c);
    qa0_r  <= (SW+1)'((SW+2)'(bc) - (SW+2)'(in_side_a));
    qb0_r  <= (SW+1)'((SW+2)'(ac) - (SW+2)'(in_side_b));
    qc0_r  <= (SW+1)'((SW+2)'(ab) - (SW+2)'(in_side_c));
  end

  // operand routing: each angle takes its own excess against the perimeter
  assign q_opp[0] = qa0_r;
  assign q_u0[0]  = qb0_r;
  assign q_u1[0]  = qc0_r;
  assign q_opp[1] = qb0_r;
  assign q_u0[1]  = qa0_r;
  assign q_u1[1]  = qc0_r;
  assign q_opp[2] = qc0_r;
  assign q_u0[2]  = qa0_r;
  assign q_u1[2]  = qb0_r;

  // one lane per angle
  for (genvar i = 0; i < 3; i++) begin : g_lane
    tafs_norm #(
      .SIDE_WIDTH(SIDE_WIDTH)
    ) u_norm (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_ctl   (ctl0_r),
      .in_sum   (sum0_r),
      .in_q_opp (q_opp[i]),
      .in_q_u0  (q_u0[i]),
      .in_q_u1  (q_u1[i]),
      .out_ctl  (norm_ctl[i]),
      .out_u    (rad_u[i]),
      .out_v    (rad_v[i])
    );

    tafs_sqrt u_sqrt_u (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_ctl   (norm_ctl[i]),
      .in_rad   (rad_u[i]),
      .out_ctl  (squ_ctl[i]),
      .out_root (root_u[i])
    );

    tafs_sqrt u_sqrt_v (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_ctl   (norm_ctl[i]),
      .in_rad   (rad_v[i]),
      .out_ctl  (sqv_ctl[i]),
      .out_root (root_v[i])
    );

    tafs_cordic #(
      .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
    ) u_cordic (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_ctl    (squ_ctl[i]),
      .in_x      (root_v[i]),
      .in_y      (root_u[i]),
      .out_ctl   (cor_ctl[i]),
      .out_angle (ang[i])
    );
  end

  // drop the angles of a rejected request
  assign out_strobe    = cor_ctl[0].vld;
  assign out_valid_res = cor_ctl[0].ok;
  assign out_angle_a   = cor_ctl[0].ok ? ang[0] : '0;
  assign out_angle_b   = cor_ctl[0].ok ? ang[1] : '0;
  assign out_angle_c   = cor_ctl[0].ok ? ang[2] : '0;

  assign ang_sum = (AW+2)'(out_angle_a) + (AW+2)'(out_angle_b) + (AW+2)'(out_angle_c);

`ifndef SYNTH
  // the lanes and both roots of each lane stay in step
  a_lane_sync: assert property (@(posedge clk) disable iff (!rst_n)
    (squ_ctl[0] == sqv_ctl[0]) && (squ_ctl[1] == sqv_ctl[1]) &&
    (squ_ctl[2] == sqv_ctl[2]) && (cor_ctl[0] == cor_ctl[1]) &&
    (cor_ctl[0] == cor_ctl[2]))
    else $error("angle lanes out of step");

  // the three angles of a real triangle add up to a straight angle
  a_angle_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_valid_res) |->
      ((ang_sum >= (AW+2)'(TGT - 3)) && (ang_sum <= (AW+2)'(TGT + 3))))
    else $error("angle sum off a straight angle");
`endif

endmodule

// ===== src/tafs_norm.sv =====
// ----------------------------------------------------------------------------
// tafs_norm: product and normalisation stages
// Forms the two exact products of one half-angle pair in split partial
// products, finds their common bit length and shifts both left by an even
// amount so the larger one fills the top two bits of the radicand.
// ----------------------------------------------------------------------------
module tafs_norm #(
  parameter int SIDE_WIDTH = tafs_pkg::SIDE_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  tafs_pkg::tafs_ctl_t              in_ctl,
  input  logic [SIDE_WIDTH+1:0]            in_sum,
  input  logic [SIDE_WIDTH:0]              in_q_opp,
  input  logic [SIDE_WIDTH:0]              in_q_u0,
  input  logic [SIDE_WIDTH:0]              in_q_u1,
  output tafs_pkg::tafs_ctl_t              out_ctl,
  output logic [tafs_pkg::NORM_BITS-1:0]   out_u,
  output logic [tafs_pkg::NORM_BITS-1:0]   out_v
);
  import tafs_pkg::*;

  localparam int OW   = SIDE_WIDTH + 2;
  localparam int LW   = OW / 2;
  localparam int HW   = OW - LW;
  localparam int PW   = 2 * OW;
  localparam int NCH  = (PW + 7) / 8;
  localparam int PADW = NCH * 8;
  localparam int CW   = $clog2(NCH);
  localparam int LMW  = $clog2(PW + 1);
  localparam int SHW  = $clog2(NORM_BITS + 1);

  logic [OW-1:0]    opa_u, opb_u, opa_v, opb_v;
  logic [LW+OW-1:0] ulo_nxt, vlo_nxt, ulo_r, vlo_r;
  logic [HW+OW-1:0] uhi_nxt, vhi_nxt, uhi_r, vhi_r;
  logic [PW-1:0]    u2_r, v2_r, u3_r, v3_r, u4_r, v4_r;
  logic [PADW-1:0]  or_pad;
  logic [PADW-1:0]  or3_r;
  logic [NCH-1:0]   flag_nxt, flag3_r;
  logic [CW-1:0]    top_idx;
  logic [7:0]       top_byte;
  logic [2:0]       top_pos;
  logic             found;
  logic [LMW-1:0]   lm_nxt, lm4_r;
  logic [SHW-1:0]   sh;
  logic [NORM_BITS-1:0] u_nxt, v_nxt, u5_r, v5_r;
  tafs_ctl_t        ctl1_r, ctl2_r, ctl3_r, ctl4_r, ctl5_r;

  // split one operand of each product into two halves
  assign opa_v = in_sum;
  assign opb_v = OW'(in_q_opp);
  assign opa_u = OW'(in_q_u0);
  assign opb_u = OW'(in_q_u1);

  assign ulo_nxt = (LW+OW)'(opa_u[LW-1:0]) * (LW+OW)'(opb_u);
  assign vlo_nxt = (LW+OW)'(opa_v[LW-1:0]) * (LW+OW)'(opb_v);
  assign uhi_nxt = (HW+OW)'(opa_u[OW-1:LW]) * (HW+OW)'(opb_u);
  assign vhi_nxt = (HW+OW)'(opa_v[OW-1:LW]) * (HW+OW)'(opb_v);

  // flag each byte of the combined products that holds a set bit
  assign or_pad = PADW'(u2_r | v2_r);
  always_comb begin
    for (int k = 0; k < NCH; k++) begin
      flag_nxt[k] = |or_pad[k*8 +: 8];
    end
  end

  // locate the highest set bit: top byte first, then bit within it
  always_comb begin
    top_idx = '0;
    found   = 1'b0;
    top_pos = '0;
    for (int k = 0; k < NCH; k++) begin
      if (flag3_r[k]) begin
        top_idx = CW'(k);
        found   = 1'b1;
      end
    end
    top_byte = or3_r[top_idx*8 +: 8];
    for (int b = 0; b < 8; b++) begin
      if (top_byte[b]) begin
        top_pos = 3'(b);
      end
    end
    if (found) begin
      lm_nxt = LMW'({top_idx, top_pos}) + LMW'(1);
    end else begin
      lm_nxt = '0;
    end
  end

  // shift by an even amount so the top bit lands in bit 119 or 118
  assign sh    = (SHW'(NORM_BITS) - SHW'(lm4_r)) & ~SHW'(1);
  assign u_nxt = NORM_BITS'(u4_r) << sh;
  assign v_nxt = NORM_BITS'(v4_r) << sh;

  // advance control through the five stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      ctl3_r <= '0;
      ctl4_r <= '0;
      ctl5_r <= '0;
    end else begin
      ctl1_r <= in_ctl;
      ctl2_r <= ctl1_r;
      ctl3_r <= ctl2_r;
      ctl4_r <= ctl3_r;
      ctl5_r <= ctl4_r;
    end
  end

  // advance the data
  always_ff @(posedge clk) begin
    ulo_r   <= ulo_nxt;
    uhi_r   <= uhi_nxt;
    vlo_r   <= vlo_nxt;
    vhi_r   <= vhi_nxt;
    u2_r    <= PW'(ulo_r) + (PW'(uhi_r) << LW);
    v2_r    <= PW'(vlo_r) + (PW'(vhi_r) << LW);
    u3_r    <= u2_r;
    v3_r    <= v2_r;
    or3_r   <= or_pad;
    flag3_r <= flag_nxt;
    u4_r    <= u3_r;
    v4_r    <= v3_r;
    lm4_r   <= lm_nxt;
    u5_r    <= u_nxt;
    v5_r    <= v_nxt;
  end

  assign out_ctl = ctl5_r;
  assign out_u   = u5_r;
  assign out_v   = v5_r;

`ifndef SYNTH
  // a valid triangle always leaves the larger radicand in the top bit pair
  a_norm_top: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ctl.vld && out_ctl.ok) |->
      (out_u[NORM_BITS-1:NORM_BITS-2] != 2'b00 ||
       out_v[NORM_BITS-1:NORM_BITS-2] != 2'b00))
    else $error("normalised radicand not aligned");
`endif

endmodule

// ===== src/tafs_sqrt.sv =====
// ----------------------------------------------------------------------------
// tafs_sqrt: pipelined integer square root
// Restoring digit recurrence, one root bit per stage, sixty stages. Takes a
// 120-bit radicand and returns its 60-bit floor square root.
// ----------------------------------------------------------------------------
module tafs_sqrt (
  input  logic                             clk,
  input  logic                             rst_n,
  input  tafs_pkg::tafs_ctl_t              in_ctl,
  input  logic [tafs_pkg::NORM_BITS-1:0]   in_rad,
  output tafs_pkg::tafs_ctl_t              out_ctl,
  output logic [tafs_pkg::ROOT_BITS-1:0]   out_root
);
  import tafs_pkg::*;

  logic [NORM_BITS-1:0] rad_in   [0:ROOT_BITS-1];
  logic [REM_BITS-1:0]  rem_in   [0:ROOT_BITS-1];
  logic [ROOT_BITS-1:0] root_in  [0:ROOT_BITS-1];
  logic [NORM_BITS-1:0] rad_nxt  [0:ROOT_BITS-1];
  logic [REM_BITS-1:0]  rem_nxt  [0:ROOT_BITS-1];
  logic [ROOT_BITS-1:0] root_nxt [0:ROOT_BITS-1];
  logic [NORM_BITS-1:0] rad_r    [1:ROOT_BITS];
  logic [REM_BITS-1:0]  rem_r    [1:ROOT_BITS];
  logic [ROOT_BITS-1:0] root_r   [1:ROOT_BITS];
  tafs_ctl_t            ctl_r    [1:ROOT_BITS];

  // one trial subtraction per stage
  always_comb begin
    logic [REM_BITS+1:0] remw;
    logic [REM_BITS+1:0] trial;
    rad_in[0]  = in_rad;
    rem_in[0]  = '0;
    root_in[0] = '0;
    for (int j = 1; j < ROOT_BITS; j++) begin
      rad_in[j]  = rad_r[j];
      rem_in[j]  = rem_r[j];
      root_in[j] = root_r[j];
    end
    for (int j = 0; j < ROOT_BITS; j++) begin
      remw       = {rem_in[j], rad_in[j][NORM_BITS-1 -: 2]};
      trial      = (REM_BITS+2)'({root_in[j], 2'b01});
      rad_nxt[j] = rad_in[j] << 2;
      if (remw >= trial) begin
        rem_nxt[j]  = REM_BITS'(remw - trial);
        root_nxt[j] = {root_in[j][ROOT_BITS-2:0], 1'b1};
      end else begin
        rem_nxt[j]  = REM_BITS'(remw);
        root_nxt[j] = {root_in[j][ROOT_BITS-2:0], 1'b0};
      end
    end
  end

  // advance control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 1; j <= ROOT_BITS; j++) begin
        ctl_r[j] <= '0;
      end
    end else begin
      ctl_r[1] <= in_ctl;
      for (int j = 2; j <= ROOT_BITS; j++) begin
        ctl_r[j] <= ctl_r[j-1];
      end
    end
  end

  // advance the partial root and remainder
  always_ff @(posedge clk) begin
    for (int j = 0; j < ROOT_BITS; j++) begin
      rad_r[j+1]  <= rad_nxt[j];
      rem_r[j+1]  <= rem_nxt[j];
      root_r[j+1] <= root_nxt[j];
    end
  end

  assign out_ctl  = ctl_r[ROOT_BITS];
  assign out_root = root_r[ROOT_BITS];

endmodule

// ===== src/tafs_cordic.sv =====
// ----------------------------------------------------------------------------
// tafs_cordic: vectoring CORDIC and degree conversion
// Thirty-one rotation stages drive y to zero and collect the half angle,
// then one stage scales it to degrees and one rounds to the output format.
// ----------------------------------------------------------------------------
module tafs_cordic #(
  parameter int ANGLE_FRAC_BITS = tafs_pkg::ANGLE_FRAC_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  tafs_pkg::tafs_ctl_t              in_ctl,
  input  logic [tafs_pkg::ROOT_BITS-1:0]   in_x,
  input  logic [tafs_pkg::ROOT_BITS-1:0]   in_y,
  output tafs_pkg::tafs_ctl_t              out_ctl,
  output logic [8+ANGLE_FRAC_BITS-1:0]     out_angle
);
  import tafs_pkg::*;

  localparam int AW     = 8 + ANGLE_FRAC_BITS;
  localparam int RND_SH = 54 - ANGLE_FRAC_BITS;
  localparam int N      = CORDIC_STEPS;

  logic signed [XY_BITS-1:0] x_in  [0:N-1];
  logic signed [XY_BITS-1:0] y_in  [0:N-1];
  logic signed [Z_BITS-1:0]  z_in  [0:N-1];
  logic signed [XY_BITS-1:0] x_nxt [0:N-1];
  logic signed [XY_BITS-1:0] y_nxt [0:N-1];
  logic signed [Z_BITS-1:0]  z_nxt [0:N-1];
  logic signed [XY_BITS-1:0] x_r   [1:N];
  logic signed [XY_BITS-1:0] y_r   [1:N];
  logic signed [Z_BITS-1:0]  z_r   [1:N];
  tafs_ctl_t                 ctl_r [1:N];
  logic [Z_BITS-2:0]         z_pos;
  logic [DEG_BITS-1:0]       prod_r, rnd;
  logic [AW-1:0]             ang_r;
  tafs_ctl_t                 ctlm_r, ctlo_r;

  // one micro-rotation per stage, direction from the sign of y
  always_comb begin
    x_in[0] = XY_BITS'(in_x);
    y_in[0] = XY_BITS'(in_y);
    z_in[0] = '0;
    for (int j = 1; j < N; j++) begin
      x_in[j] = x_r[j];
      y_in[j] = y_r[j];
      z_in[j] = z_r[j];
    end
    for (int j = 0; j < N; j++) begin
      if (y_in[j] >= 0) begin
        x_nxt[j] = x_in[j] + (y_in[j] >>> j);
        y_nxt[j] = y_in[j] - (x_in[j] >>> j);
        z_nxt[j] = z_in[j] + atan_q30(5'(j));
      end else begin
        x_nxt[j] = x_in[j] - (y_in[j] >>> j);
        y_nxt[j] = y_in[j] + (x_in[j] >>> j);
        z_nxt[j] = z_in[j] - atan_q30(5'(j));
      end
    end
  end

  // clamp a negative half angle to zero
  assign z_pos = (z_r[N] < 0) ? '0 : z_r[N][Z_BITS-2:0];

  // round half up to the output format
  assign rnd = prod_r + (DEG_BITS'(1) << (RND_SH - 1));

  // advance control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 1; j <= N; j++) begin
        ctl_r[j] <= '0;
      end
      ctlm_r <= '0;
      ctlo_r <= '0;
    end else begin
      ctl_r[1] <= in_ctl;
      for (int j = 2; j <= N; j++) begin
        ctl_r[j] <= ctl_r[j-1];
      end
      ctlm_r <= ctl_r[N];
      ctlo_r <= ctlm_r;
    end
  end

  // advance the rotation, scale and rounding stages
  always_ff @(posedge clk) begin
    for (int j = 0; j < N; j++) begin
      x_r[j+1] <= x_nxt[j];
      y_r[j+1] <= y_nxt[j];
      z_r[j+1] <= z_nxt[j];
    end
    prod_r <= DEG_BITS'(z_pos) * DEG_BITS'(DEG_PER_RAD_X2);
    ang_r  <= AW'(rnd >> RND_SH);
  end

  assign out_ctl   = ctlo_r;
  assign out_angle = ang_r;

endmodule
